// File: src/lwrl_pkg.sv
// shared types, constants and helpers for the loss window request limiter
`default_nettype none

package lwrl_pkg;

  localparam int unsigned LOSS_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(LOSS_DEPTH);
  localparam int unsigned FILL_W     = $clog2(LOSS_DEPTH + 1);
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned NS_W       = 40;
  localparam int unsigned THR_W      = 7;
  localparam int unsigned KBPS_W     = 20;
  localparam int unsigned CNT_OUT_W  = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BR_HOLDOFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KF_HOLDOFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_KBPS    = 3'd4;

  // request types
  localparam logic [2:0] REQ_LOSS     = 3'd0;
  localparam logic [2:0] REQ_FAILURE  = 3'd1;
  localparam logic [2:0] REQ_POLL_BR  = 3'd2;
  localparam logic [2:0] REQ_POLL_KF  = 3'd3;
  localparam logic [2:0] REQ_COUNT    = 3'd4;

  // reset values of the configuration registers
  localparam logic [NS_W-1:0]   RST_WINDOW     = 40'd1000000000;
  localparam logic [THR_W-1:0]  RST_THRESHOLD  = 7'd3;
  localparam logic [NS_W-1:0]   RST_BR_HOLDOFF = 40'd1000000000;
  localparam logic [NS_W-1:0]   RST_KF_HOLDOFF = 40'd500000000;
  localparam logic [KBPS_W-1:0] RST_STEP_KBPS  = 20'd2000;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [TIME_W-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic                 bitrate_request;
    logic [KBPS_W-1:0]    requested_kbps;
    logic                 keyframe_request;
    logic [CNT_OUT_W-1:0] loss_count;
  } out_t;

  typedef struct packed {
    logic [NS_W-1:0]   window_ns;
    logic [THR_W-1:0]  loss_threshold;
    logic [NS_W-1:0]   bitrate_holdoff_ns;
    logic [NS_W-1:0]   keyframe_holdoff_ns;
    logic [KBPS_W-1:0] step_down_kbps;
  } cfg_t;

  typedef struct packed {
    logic              idle;
    logic [FILL_W-1:0] fill;
  } eng_stat_t;

  // next ring slot with wrap at the ring depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(LOSS_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  // loss count clipped to the output field
  function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [FILL_W-1:0] c);
    logic [31:0] w;
    logic [CNT_OUT_W-1:0] r;
    w = 32'(c);
    if (w > 32'd127) r = 7'd127;
    else r = w[CNT_OUT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/lwrl_ring_ram.sv
// single-port-write, single-port-read ram with registered read data
`default_nettype none

module lwrl_ring_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/lwrl_cfg_regs.sv
// configuration register bank
`default_nettype none

module lwrl_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [lwrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lwrl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lwrl_pkg::cfg_t                       cfg_o
);

  lwrl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lwrl_pkg::REG_WINDOW: begin
          cfg_d.window_ns = cfg_data_i[lwrl_pkg::NS_W-1:0];
        end
        lwrl_pkg::REG_THRESHOLD: begin
          cfg_d.loss_threshold = cfg_data_i[lwrl_pkg::THR_W-1:0];
        end
        lwrl_pkg::REG_BR_HOLDOFF: begin
          cfg_d.bitrate_holdoff_ns = cfg_data_i[lwrl_pkg::NS_W-1:0];
        end
        lwrl_pkg::REG_KF_HOLDOFF: begin
          cfg_d.keyframe_holdoff_ns = cfg_data_i[lwrl_pkg::NS_W-1:0];
        end
        lwrl_pkg::REG_STEP_KBPS: begin
          cfg_d.step_down_kbps = cfg_data_i[lwrl_pkg::KBPS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ns           <= lwrl_pkg::RST_WINDOW;
      cfg_q.loss_threshold      <= lwrl_pkg::RST_THRESHOLD;
      cfg_q.bitrate_holdoff_ns  <= lwrl_pkg::RST_BR_HOLDOFF;
      cfg_q.keyframe_holdoff_ns <= lwrl_pkg::RST_KF_HOLDOFF;
      cfg_q.step_down_kbps      <= lwrl_pkg::RST_STEP_KBPS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/lwrl_engine.sv
// sequencer: prunes, updates and scans the loss-time ring held in ram
`default_nettype none

module lwrl_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lwrl_pkg::cfg_t cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lwrl_pkg::in_t  in_data_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output lwrl_pkg::out_t      res_o,
  output lwrl_pkg::eng_stat_t stat_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PR_RD  = 3'd1;
  localparam logic [2:0] ST_PR_CHK = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_CNT    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  localparam int unsigned SUM_W = lwrl_pkg::FILL_W + 1;

  logic [2:0]                      state_q, state_d;
  logic [2:0]                      kind_q, kind_d;
  logic [lwrl_pkg::TIME_W-1:0]     now_q, now_d;
  logic [lwrl_pkg::PTR_W-1:0]      head_q, head_d;
  logic [lwrl_pkg::FILL_W-1:0]     fill_q, fill_d;
  logic                            pend_q, pend_d;
  logic [lwrl_pkg::TIME_W-1:0]     last_br_q, last_br_d;
  logic [lwrl_pkg::TIME_W-1:0]     last_kf_q, last_kf_d;
  logic                            br_q, br_d;
  logic                            kf_q, kf_d;
  logic [lwrl_pkg::KBPS_W-1:0]     kbps_q, kbps_d;
  logic [lwrl_pkg::PTR_W-1:0]      scan_q, scan_d;
  logic [lwrl_pkg::FILL_W-1:0]     issued_q, issued_d;
  logic [lwrl_pkg::FILL_W-1:0]     cnt_q, cnt_d;
  logic                            rv_q, rv_d;

  logic                            ram_we, ram_re;
  logic [lwrl_pkg::PTR_W-1:0]      ram_waddr, ram_raddr;
  logic [lwrl_pkg::TIME_W-1:0]     ram_rdata;

  logic [lwrl_pkg::TIME_W-1:0]     age;
  logic                            in_window;
  logic [SUM_W-1:0]                tail_sum;
  logic [lwrl_pkg::PTR_W-1:0]      tail_ptr;
  logic                            ring_full;
  logic [lwrl_pkg::TIME_W-1:0]     br_gap, kf_gap;
  logic                            br_ok, kf_ok;

  lwrl_ring_ram #(
    .DEPTH (lwrl_pkg::LOSS_DEPTH),
    .WIDTH (lwrl_pkg::TIME_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (now_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // age of the entry just read, modulo 2^64
  assign age       = now_q - ram_rdata;
  assign in_window = (age <= {{(lwrl_pkg::TIME_W - lwrl_pkg::NS_W){1'b0}}, cfg_i.window_ns});

  // slot after the newest entry; a full ring wraps onto the head
  assign tail_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
  assign tail_ptr  = (tail_sum >= SUM_W'(lwrl_pkg::LOSS_DEPTH)) ?
                     lwrl_pkg::PTR_W'(tail_sum - SUM_W'(lwrl_pkg::LOSS_DEPTH)) :
                     lwrl_pkg::PTR_W'(tail_sum);
  assign ring_full = (fill_q == lwrl_pkg::FILL_W'(lwrl_pkg::LOSS_DEPTH));

  assign br_gap = now_q - last_br_q;
  assign kf_gap = now_q - last_kf_q;
  assign br_ok  = (32'(fill_q) > 32'(cfg_i.loss_threshold)) &&
                  ((last_br_q == '0) ||
                   (br_gap >= {{(lwrl_pkg::TIME_W - lwrl_pkg::NS_W){1'b0}},
                               cfg_i.bitrate_holdoff_ns}));
  assign kf_ok  = pend_q &&
                  ((last_kf_q == '0) ||
                   (kf_gap >= {{(lwrl_pkg::TIME_W - lwrl_pkg::NS_W){1'b0}},
                               cfg_i.keyframe_holdoff_ns}));

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    now_d     = now_q;
    head_d    = head_q;
    fill_d    = fill_q;
    pend_d    = pend_q;
    last_br_d = last_br_q;
    last_kf_d = last_kf_q;
    br_d      = br_q;
    kf_d      = kf_q;
    kbps_d    = kbps_q;
    scan_d    = scan_q;
    issued_d  = issued_q;
    cnt_d     = cnt_q;
    rv_d      = rv_q;
    ram_we    = 1'b0;
    ram_waddr = tail_ptr;
    ram_re    = 1'b0;
    ram_raddr = head_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = in_data_i.req_type;
          now_d  = in_data_i.now_time;
          br_d   = 1'b0;
          kf_d   = 1'b0;
          kbps_d = '0;
          if (in_data_i.req_type == lwrl_pkg::REQ_LOSS ||
              in_data_i.req_type == lwrl_pkg::REQ_POLL_BR) begin
            state_d = ST_PR_RD;
          end else begin
            state_d = ST_UPD;
          end
        end
      end
      ST_PR_RD: begin
        if (fill_q == '0) begin
          state_d = ST_UPD;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_PR_CHK;
        end
      end
      ST_PR_CHK: begin
        if (!in_window) begin
          head_d  = lwrl_pkg::ptr_inc(head_q);
          fill_d  = fill_q - lwrl_pkg::FILL_W'(1);
          state_d = ST_PR_RD;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        case (kind_q)
          lwrl_pkg::REQ_LOSS: begin
            ram_we = 1'b1;
            if (ring_full) begin
              head_d = lwrl_pkg::ptr_inc(head_q);
            end else begin
              fill_d = fill_q + lwrl_pkg::FILL_W'(1);
            end
          end
          lwrl_pkg::REQ_FAILURE: begin
            pend_d = 1'b1;
          end
          lwrl_pkg::REQ_POLL_BR: begin
            if (br_ok) begin
              last_br_d = now_q;
              br_d      = 1'b1;
              kbps_d    = cfg_i.step_down_kbps;
            end
          end
          lwrl_pkg::REQ_POLL_KF: begin
            if (kf_ok) begin
              last_kf_d = now_q;
              pend_d    = 1'b0;
              kf_d      = 1'b1;
            end
          end
          default: begin
          end
        endcase
        scan_d   = head_d;
        issued_d = '0;
        cnt_d    = '0;
        rv_d     = 1'b0;
        state_d  = ST_CNT;
      end
      ST_CNT: begin
        // one read issued per cycle, compared in the cycle after it is issued
        rv_d = 1'b0;
        if (issued_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = scan_q;
          scan_d    = lwrl_pkg::ptr_inc(scan_q);
          issued_d  = issued_q + lwrl_pkg::FILL_W'(1);
          rv_d      = 1'b1;
        end
        if (rv_q && in_window) begin
          cnt_d = cnt_q + lwrl_pkg::FILL_W'(1);
        end
        if (issued_q == fill_q && !rv_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      pend_q    <= 1'b0;
      last_br_q <= '0;
      last_kf_q <= '0;
      issued_q  <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      pend_q    <= pend_d;
      last_br_q <= last_br_d;
      last_kf_q <= last_kf_d;
      issued_q  <= issued_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    now_q  <= now_d;
    br_q   <= br_d;
    kf_q   <= kf_d;
    kbps_q <= kbps_d;
    scan_q <= scan_d;
    cnt_q  <= cnt_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_FIN);

  assign res_o.bitrate_request  = br_q;
  assign res_o.requested_kbps   = kbps_q;
  assign res_o.keyframe_request = kf_q;
  assign res_o.loss_count       = lwrl_pkg::sat_count(cnt_q);

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.fill = fill_q;

endmodule

`default_nettype wire

// File: src/loss_window_request_limiter_core.sv
// a loss or bitrate poll prunes expired losses from the ring head, then updates and scans the ring;
//   other requests update and scan without a prune; the engine takes one item at a time
// result sits in an output register so the next item is taken while it waits
// reset: asynchronous active low; clears ring pointers, fill, last request times, the
//   pending flag and the configuration to its defaults; ring ram contents are not cleared
`default_nettype none

module loss_window_request_limiter_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lwrl_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lwrl_pkg::out_t                       out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [lwrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lwrl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  lwrl_pkg::cfg_t      cfg;
  lwrl_pkg::out_t      res;
  lwrl_pkg::eng_stat_t stat;
  logic                res_valid, res_ready, load;
  lwrl_pkg::out_t      out_q;
  logic                out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  lwrl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lwrl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .stat_o      (stat)
  );

  // output register frees up when its beat is taken
  assign res_ready = !out_valid_q || out_ready_i;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stat.fill) <= 32'(lwrl_pkg::LOSS_DEPTH))
    else $error("ring fill beyond depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !stat.idle)
    else $error("engine idle right after accepting a beat");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_o)
    else $error("finished result not presented");

  a_kbps_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.bitrate_request) |-> (out_data_o.requested_kbps == '0))
    else $error("bitrate value without a request");

endmodule

`default_nettype wire
